// ===== hdl/bsp_pkg.sv =====
// Shared types, codes and defaults of the blocked slot pool.
`default_nettype none
package bsp_pkg;

   localparam int SLOTS_PER_BLOCK_DEF = 64;
   localparam int NUM_BLOCKS_DEF      = 16;
   localparam int VALUE_BITS_DEF      = 32;

   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int BLOCK_W  = 4;
   localparam int SLOT_W   = 6;
   localparam int TOTAL_W  = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_ERASE  = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_ZERO      = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,       // capture request, rewind block and slot counters
      OP_CLEAR,      // drop all blocks
      OP_BLK_NEXT,   // advance block, rewind slot
      OP_SLOT_NEXT,  // advance slot
      OP_ALLOC,      // open the block under the block counter
      OP_READ_HEAD,  // read the freelist head entry of the current block
      OP_READ_SLOT,  // read the current slot entry
      OP_INS_COMMIT,
      OP_ERS_COMMIT,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
      logic       success;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     value_zero;
      logic     blk_end;
      logic     pool_full;
      logic     head_avail;
      logic     blk_live;
      logic     slot_end;
      logic     match;
      logic     out_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== hdl/blocked_slot_pool.sv =====
// Top level of the blocked slot pool: sequencer plus datapath.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  req     | in  | req_tvalid/req_tready  | tuser kind, tdata value
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata status, block, slot, totals
//
// Clear, no-op and zero-value requests go from dispatch straight to the
// result. Insert passes over each allocated block without a free slot,
// then reads the freelist head of the chosen or newly opened block and
// commits. Erase visits each block and, in a block with live slots, reads
// each touched slot in turn (the slot store read is registered) until a
// match is found or the walk ends.
// Reset is synchronous; it empties the pool at once, with no clearing pass.
// A waiting result does not block the next request; a new result waits in
// the sequencer while the previous one is still unaccepted.
`default_nettype none
module blocked_slot_pool #(
   parameter int SLOTS_PER_BLOCK = bsp_pkg::SLOTS_PER_BLOCK_DEF,
   parameter int NUM_BLOCKS      = bsp_pkg::NUM_BLOCKS_DEF,
   parameter int VALUE_BITS      = bsp_pkg::VALUE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [1:0] status, [5:2] block_index,
                                         // [11:6] slot_index, [22:12] live_total,
                                         // [33:23] capacity_total, [39:34] zero
);

   bsp_pkg::cmd_type cmd;
   bsp_pkg::sts_type sts;

   logic [bsp_pkg::STATUS_W-1:0] status;
   logic [bsp_pkg::BLOCK_W-1:0]  block_index;
   logic [bsp_pkg::SLOT_W-1:0]   slot_index;
   logic [bsp_pkg::TOTAL_W-1:0]  live_total;
   logic [bsp_pkg::TOTAL_W-1:0]  capacity_total;

   bsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bsp_dp #(
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .NUM_BLOCKS      (NUM_BLOCKS),
      .VALUE_BITS      (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req_tuser),
      .req_value    (req_tdata),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (status),
      .rsp_block    (block_index),
      .rsp_slot     (slot_index),
      .rsp_live     (live_total),
      .rsp_capacity (capacity_total)
   );

   // pack the result transfer, first field lowest
   assign rsp_tdata = {6'd0, capacity_total, live_total, slot_index, block_index, status};

endmodule
`default_nettype wire

// ===== hdl/bsp_ctrl.sv =====
// Request sequencer of the blocked slot pool.
`default_nettype none
module bsp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire bsp_pkg::sts_type  sts,
   output bsp_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_SCAN,
      ST_INS_READ,
      ST_INS_COMMIT,
      ST_ERS_BLK,
      ST_ERS_READ,
      ST_ERS_CHECK,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   bsp_pkg::status_type  res_status_ff, res_status_in;
   logic                 res_ok_ff, res_ok_in;

   always_comb begin
      state_in      = state_ff;
      res_status_in = res_status_ff;
      res_ok_in     = res_ok_ff;
      cmd.op        = bsp_pkg::OP_IDLE;
      cmd.status    = res_status_ff;
      cmd.success   = res_ok_ff;
      req_tready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = bsp_pkg::OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_status_in = bsp_pkg::STAT_OK;
            res_ok_in     = 1'b0;
            state_in      = ST_EMIT;
            if (sts.kind == bsp_pkg::KIND_CLEAR) begin
               cmd.op = bsp_pkg::OP_CLEAR;
            end else if (sts.kind == bsp_pkg::KIND_NOP) begin
               state_in = ST_EMIT;
            end else if (sts.value_zero) begin
               res_status_in = bsp_pkg::STAT_ZERO;
            end else if (sts.kind == bsp_pkg::KIND_INSERT) begin
               state_in = ST_INS_SCAN;
            end else begin
               state_in = ST_ERS_BLK;
            end
         end
         ST_INS_SCAN: begin
            if (sts.blk_end) begin
               if (sts.pool_full) begin
                  res_status_in = bsp_pkg::STAT_FULL;
                  state_in      = ST_EMIT;
               end else begin
                  cmd.op   = bsp_pkg::OP_ALLOC;
                  state_in = ST_INS_READ;
               end
            end else if (sts.head_avail) begin
               state_in = ST_INS_READ;
            end else begin
               cmd.op = bsp_pkg::OP_BLK_NEXT;
            end
         end
         ST_INS_READ: begin
            cmd.op   = bsp_pkg::OP_READ_HEAD;
            state_in = ST_INS_COMMIT;
         end
         ST_INS_COMMIT: begin
            cmd.op    = bsp_pkg::OP_INS_COMMIT;
            res_ok_in = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_ERS_BLK: begin
            if (sts.blk_end) begin
               res_status_in = bsp_pkg::STAT_NOT_FOUND;
               state_in      = ST_EMIT;
            end else if (sts.blk_live) begin
               state_in = ST_ERS_READ;
            end else begin
               cmd.op = bsp_pkg::OP_BLK_NEXT;
            end
         end
         ST_ERS_READ: begin
            if (sts.slot_end) begin
               cmd.op   = bsp_pkg::OP_BLK_NEXT;
               state_in = ST_ERS_BLK;
            end else begin
               cmd.op   = bsp_pkg::OP_READ_SLOT;
               state_in = ST_ERS_CHECK;
            end
         end
         ST_ERS_CHECK: begin
            if (sts.match) begin
               cmd.op    = bsp_pkg::OP_ERS_COMMIT;
               res_ok_in = 1'b1;
               state_in  = ST_EMIT;
            end else begin
               cmd.op   = bsp_pkg::OP_SLOT_NEXT;
               state_in = ST_ERS_READ;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.op   = bsp_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         res_status_ff <= bsp_pkg::STAT_OK;
         res_ok_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         res_status_ff <= res_status_in;
         res_ok_ff     <= res_ok_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/bsp_dp.sv =====
// Slot store, block tables, counters and result register of the slot pool.
`default_nettype none
module bsp_dp #(
   parameter int SLOTS_PER_BLOCK = bsp_pkg::SLOTS_PER_BLOCK_DEF,
   parameter int NUM_BLOCKS      = bsp_pkg::NUM_BLOCKS_DEF,
   parameter int VALUE_BITS      = bsp_pkg::VALUE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [bsp_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [bsp_pkg::VALUE_W-1:0]    req_value,
   input  wire bsp_pkg::cmd_type               cmd,
   output bsp_pkg::sts_type                    sts,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [bsp_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bsp_pkg::BLOCK_W-1:0]         rsp_block,
   output logic [bsp_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [bsp_pkg::TOTAL_W-1:0]         rsp_live,
   output logic [bsp_pkg::TOTAL_W-1:0]         rsp_capacity
);

   localparam int VW    = (VALUE_BITS < bsp_pkg::VALUE_W) ? VALUE_BITS : bsp_pkg::VALUE_W;
   localparam int HB    = $clog2(SLOTS_PER_BLOCK + 1);
   localparam int SB    = $clog2(SLOTS_PER_BLOCK);
   localparam int SW    = (VW > HB) ? VW : HB;
   localparam int BB    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CB    = $clog2(NUM_BLOCKS + 1);
   localparam int LW    = $clog2(SLOTS_PER_BLOCK * NUM_BLOCKS + 1);
   localparam int AW    = BB + SB;
   localparam int DEPTH = 1 << AW;

   // entry: dead flag above either the live value or the freelist link
   logic [SW:0]   mem [DEPTH];
   logic [SW:0]   rd_ff;

   logic [HB-1:0] head_ff [NUM_BLOCKS];
   logic [HB-1:0] bcount_ff [NUM_BLOCKS];
   logic [HB-1:0] fill_ff [NUM_BLOCKS];   // slots at or above this are untouched

   logic [CB-1:0]             inuse_ff;
   logic [LW-1:0]             total_ff;
   logic [CB-1:0]             blk_ff;
   logic [HB-1:0]             slot_ff;
   logic [bsp_pkg::KIND_W-1:0] kind_ff;
   logic [VW-1:0]             value_ff;
   logic                      rsp_valid_ff;

   logic [BB-1:0] bidx;
   logic [SB-1:0] sidx;
   logic [HB-1:0] head_cur, fill_cur, link, nhead;
   logic [AW-1:0] rd_addr;
   logic          fresh;
   logic [31:0]   blk_wide, slot_wide, live_wide, cap_wide;

   assign bidx     = blk_ff[BB-1:0];
   assign sidx     = slot_ff[SB-1:0];
   assign head_cur = head_ff[bidx];
   assign fill_cur = fill_ff[bidx];
   assign rd_addr  = (cmd.op == bsp_pkg::OP_READ_HEAD) ? {bidx, head_cur[SB-1:0]}
                                                        : {bidx, sidx};
   assign fresh    = head_cur >= fill_cur;
   assign link     = fresh ? HB'(head_cur + 1'b1) : rd_ff[HB-1:0];
   assign nhead    = (link < HB'(SLOTS_PER_BLOCK)) ? link : HB'(SLOTS_PER_BLOCK);

   always_comb begin
      sts.kind       = bsp_pkg::kind_type'(kind_ff);
      sts.value_zero = (value_ff == '0);
      sts.blk_end    = (blk_ff == inuse_ff);
      sts.pool_full  = (inuse_ff == CB'(NUM_BLOCKS));
      sts.head_avail = (blk_ff < inuse_ff) && (head_cur < HB'(SLOTS_PER_BLOCK));
      sts.blk_live   = (bcount_ff[bidx] != '0);
      sts.slot_end   = (slot_ff == fill_cur);
      sts.match      = !rd_ff[SW] && (rd_ff[SW-1:0] == SW'(value_ff));
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // slot store
   always_ff @(posedge clock) begin
      if (cmd.op == bsp_pkg::OP_READ_HEAD || cmd.op == bsp_pkg::OP_READ_SLOT) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.op == bsp_pkg::OP_INS_COMMIT) begin
         mem[{bidx, head_cur[SB-1:0]}] <= {1'b0, SW'(value_ff)};
      end else if (cmd.op == bsp_pkg::OP_ERS_COMMIT) begin
         mem[{bidx, sidx}] <= {1'b1, SW'(head_cur)};
      end
   end

   // block tables and request capture
   always_ff @(posedge clock) begin
      case (cmd.op)
         bsp_pkg::OP_LOAD: begin
            kind_ff  <= req_kind;
            value_ff <= req_value[VW-1:0];
            blk_ff   <= '0;
            slot_ff  <= '0;
         end
         bsp_pkg::OP_BLK_NEXT: begin
            blk_ff  <= blk_ff + 1'b1;
            slot_ff <= '0;
         end
         bsp_pkg::OP_SLOT_NEXT: begin
            slot_ff <= slot_ff + 1'b1;
         end
         bsp_pkg::OP_ALLOC: begin
            head_ff[bidx]   <= '0;
            bcount_ff[bidx] <= '0;
            fill_ff[bidx]   <= '0;
         end
         bsp_pkg::OP_INS_COMMIT: begin
            head_ff[bidx]   <= nhead;
            bcount_ff[bidx] <= bcount_ff[bidx] + 1'b1;
            slot_ff         <= head_cur;
            if (fresh) begin
               fill_ff[bidx] <= HB'(head_cur + 1'b1);
            end
         end
         bsp_pkg::OP_ERS_COMMIT: begin
            head_ff[bidx]   <= slot_ff;
            bcount_ff[bidx] <= bcount_ff[bidx] - 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign blk_wide  = 32'(blk_ff);
   assign slot_wide = 32'(slot_ff);
   assign live_wide = 32'(total_ff);
   assign cap_wide  = 32'(inuse_ff) * 32'(SLOTS_PER_BLOCK);

   // totals and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         inuse_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            bsp_pkg::OP_CLEAR: begin
               inuse_ff <= '0;
               total_ff <= '0;
            end
            bsp_pkg::OP_ALLOC:      inuse_ff <= inuse_ff + 1'b1;
            bsp_pkg::OP_INS_COMMIT: total_ff <= total_ff + 1'b1;
            bsp_pkg::OP_ERS_COMMIT: total_ff <= total_ff - 1'b1;
            default: begin
            end
         endcase
         if (cmd.op == bsp_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == bsp_pkg::OP_EMIT) begin
         rsp_status   <= cmd.status;
         rsp_block    <= cmd.success ? blk_wide[bsp_pkg::BLOCK_W-1:0] : '0;
         rsp_slot     <= cmd.success ? slot_wide[bsp_pkg::SLOT_W-1:0] : '0;
         rsp_live     <= live_wide[bsp_pkg::TOTAL_W-1:0];
         rsp_capacity <= cap_wide[bsp_pkg::TOTAL_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/bsp_chk.sv =====
// Port checker of the blocked slot pool and its bind.
`default_nettype none
module bsp_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before transfer");

   // drop ready after a request transfer: one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // block and slot only on success
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != bsp_pkg::STAT_OK |-> rsp_tdata[11:2] == '0)
      else $error("index reported on a failed request");

   // live items never exceed capacity
   a_live_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:12] <= rsp_tdata[33:23])
      else $error("live total above capacity");

endmodule

bind blocked_slot_pool bsp_chk u_bsp_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
